// File: src/pst_pkg.sv
// ----------------------------------------------------------------------------
// Process slot table package
// Shared types, opcodes, slot states and sequencer states.
// ----------------------------------------------------------------------------
package pst_pkg;

   localparam int SLOTS_DEF       = 32;
   localparam int THREAD_BITS_DEF = 16;

   typedef enum logic [2:0] {
      OP_CREATE = 3'd0,
      OP_ATTACH = 3'd1,
      OP_TEND   = 3'd2,
      OP_REAP   = 3'd3,
      OP_FIND   = 3'd4,
      OP_NTH    = 3'd5
   } op_type;

   localparam logic [1:0] ST_FREE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_END  = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_READ,
      S_WAIT,
      S_WRITE,
      S_DONE
   } seq_type;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [31:0]        proc_id;
      logic [31:0]        parent_id;
      logic [31:0]        user_id;
      logic [31:0]        group_id;
      logic signed [63:0] exit_value;
      logic [4:0]         ordinal;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [4:0]         slot_index;
      logic [31:0]        id_out;
      logic [1:0]         status_out;
      logic signed [63:0] code_out;
      logic [31:0]        parent_out;
      logic [31:0]        user_out;
      logic [31:0]        group_out;
      logic [15:0]        thread_count;
      logic               ended_now;
      logic [5:0]         live_count;
   } rsp_type;

endpackage

// File: src/pst_store.sv
// ----------------------------------------------------------------------------
// Process slot table record store
// Slot records in one memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pst_store #(
   parameter int SLOTS       = pst_pkg::SLOTS_DEF,
   parameter int THREAD_BITS = pst_pkg::THREAD_BITS_DEF,
   parameter int AW          = $clog2(SLOTS),
   parameter int RW          = 32 + 32 + 32 + 64 + THREAD_BITS
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [RW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [RW-1:0] rd_data
);

   logic [RW-1:0] mem [SLOTS];
   logic [RW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/process_slot_table_unit.sv
// ----------------------------------------------------------------------------
// Process slot table unit
// Table of task slots with create, attach, thread end, reap, find and nth.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_stall/req_word carry one operation; rsp_valid/rsp_stall/
//   rsp_word return exactly one result per operation.
//   Slot states and ids sit in flip-flops; the other record fields sit in
//   a memory with one write port and one registered read port. One shared
//   compare unit walks the slots one per cycle. After a hit the sequencer
//   steps through read, read wait, write and result states; a miss goes
//   from the scan of the last slot straight to the result state.
//   The block takes a new word only when the result register is empty or
//   being taken in the same cycle, so it runs one operation at a time.
//   Reset frees all slots and sets the id counter to one; no clearing pass.
//   While rsp_stall is high and a result is pending, the result holds and no new word is taken.
// ----------------------------------------------------------------------------
module process_slot_table_unit #(
   parameter int SLOTS       = pst_pkg::SLOTS_DEF,
   parameter int THREAD_BITS = pst_pkg::THREAD_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pst_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pst_pkg::rsp_type rsp_word
);

   localparam int AW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int TB = THREAD_BITS;
   localparam int RW = 32 + 32 + 32 + 64 + TB;
   localparam int RSPW = $bits(pst_pkg::rsp_type);
   localparam logic [TB-1:0] TMAX = {TB{1'b1}};
   localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

   pst_pkg::seq_type state_ff, state_in;
   pst_pkg::req_type req_ff;
   logic [1:0]       st_ff [SLOTS];
   logic [31:0]      id_ff [SLOTS];
   logic [31:0]      ctr_ff;
   logic [AW-1:0]    idx_ff;
   logic [AW-1:0]    hit_ff;
   logic             found_ff;
   logic [CW-1:0]    live_ff;
   logic [CW-1:0]    nseen_ff;
   logic             rsp_valid_ff;
   pst_pkg::rsp_type rsp_ff;

   logic          wr_en;
   logic [RW-1:0] wr_data, rd_data;
   logic          match;
   logic          accept;

   logic [31:0]   r_par, r_usr, r_grp;
   logic [63:0]   r_exit;
   logic [TB-1:0] r_thr, n_thr;
   logic [63:0]   n_exit;
   logic [1:0]    n_st;
   logic          ended;
   logic          do_write;

   pst_store #(.SLOTS(SLOTS), .THREAD_BITS(THREAD_BITS), .AW(AW), .RW(RW)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (hit_ff),
      .wr_data (wr_data),
      .rd_addr (hit_ff),
      .rd_data (rd_data)
   );

   assign {r_par, r_usr, r_grp, r_exit, r_thr} = rd_data;
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != pst_pkg::S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // shared slot compare
   always_comb begin
      match = 1'b0;
      unique case (req_ff.opcode)
         pst_pkg::OP_CREATE: match = (st_ff[idx_ff] == pst_pkg::ST_FREE);
         pst_pkg::OP_ATTACH, pst_pkg::OP_FIND:
            match = (st_ff[idx_ff] != pst_pkg::ST_FREE) && (id_ff[idx_ff] == req_ff.proc_id)
                    && (req_ff.proc_id != 32'd0);
         pst_pkg::OP_TEND:
            match = (st_ff[idx_ff] == pst_pkg::ST_RUN) && (id_ff[idx_ff] == req_ff.proc_id)
                    && (req_ff.proc_id != 32'd0);
         pst_pkg::OP_REAP:
            match = (st_ff[idx_ff] == pst_pkg::ST_END) && (id_ff[idx_ff] == req_ff.proc_id)
                    && (req_ff.proc_id != 32'd0);
         pst_pkg::OP_NTH:
            match = (st_ff[idx_ff] != pst_pkg::ST_FREE)
                    && (nseen_ff == CW'(req_ff.ordinal));
         default: match = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pst_pkg::S_IDLE:  if (accept) state_in = pst_pkg::S_SCAN;
         pst_pkg::S_SCAN:
            if (match) state_in = pst_pkg::S_READ;
            else if (idx_ff == LAST) state_in = pst_pkg::S_DONE;
         pst_pkg::S_READ:  state_in = pst_pkg::S_WAIT;
         pst_pkg::S_WAIT:  state_in = pst_pkg::S_WRITE;
         pst_pkg::S_WRITE: state_in = pst_pkg::S_DONE;
         pst_pkg::S_DONE:  state_in = pst_pkg::S_IDLE;
         default:          state_in = pst_pkg::S_IDLE;
      endcase
   end

   // record update
   always_comb begin
      n_thr  = r_thr;
      n_exit = r_exit;
      n_st   = st_ff[hit_ff];
      ended  = 1'b0;
      do_write = 1'b0;
      case (req_ff.opcode)
         pst_pkg::OP_CREATE: begin
            n_st = pst_pkg::ST_RUN;
         end
         pst_pkg::OP_ATTACH: begin
            do_write = 1'b1;
            if (r_thr != TMAX) n_thr = r_thr + TB'(1);
         end
         pst_pkg::OP_TEND: begin
            do_write = 1'b1;
            if (r_exit == 64'd0) n_exit = req_ff.exit_value;
            if (r_thr != '0) n_thr = r_thr - TB'(1);
            if (n_thr == '0) begin
               n_st  = pst_pkg::ST_END;
               ended = 1'b1;
            end
         end
         pst_pkg::OP_REAP: n_st = pst_pkg::ST_FREE;
         default: ;
      endcase
   end

   assign wr_en = (state_ff == pst_pkg::S_WRITE) &&
                  (do_write || req_ff.opcode == pst_pkg::OP_CREATE);
   assign wr_data = (req_ff.opcode == pst_pkg::OP_CREATE) ?
                    {req_ff.parent_id, req_ff.user_id, req_ff.group_id, 64'd0, {TB{1'b0}}} :
                    {r_par, r_usr, r_grp, n_exit, n_thr};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pst_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         ctr_ff       <= 32'd1;
         live_ff      <= '0;
         for (int i = 0; i < SLOTS; i++) st_ff[i] <= pst_pkg::ST_FREE;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            pst_pkg::S_IDLE: begin
               if (accept) begin
                  req_ff   <= req_word;
                  idx_ff   <= '0;
                  nseen_ff <= '0;
                  found_ff <= 1'b0;
               end
            end
            pst_pkg::S_SCAN: begin
               if (match) begin
                  hit_ff   <= idx_ff;
                  found_ff <= 1'b1;
               end else begin
                  idx_ff <= idx_ff + AW'(1);
                  if (st_ff[idx_ff] != pst_pkg::ST_FREE) nseen_ff <= nseen_ff + CW'(1);
               end
            end
            pst_pkg::S_WRITE: begin
               rsp_ff.ok         <= 1'b1;
               rsp_ff.slot_index <= 5'(hit_ff);
               rsp_ff.ended_now  <= ended;
               rsp_ff.status_out <= n_st;
               if (req_ff.opcode == pst_pkg::OP_CREATE) begin
                  id_ff[hit_ff]       <= ctr_ff;
                  ctr_ff              <= (ctr_ff == 32'hFFFF_FFFF) ? 32'd1 : ctr_ff + 32'd1;
                  live_ff             <= live_ff + CW'(1);
                  rsp_ff.id_out       <= ctr_ff;
                  rsp_ff.code_out     <= '0;
                  rsp_ff.parent_out   <= req_ff.parent_id;
                  rsp_ff.user_out     <= req_ff.user_id;
                  rsp_ff.group_out    <= req_ff.group_id;
                  rsp_ff.thread_count <= '0;
               end else begin
                  if (req_ff.opcode == pst_pkg::OP_REAP) live_ff <= live_ff - CW'(1);
                  rsp_ff.id_out       <= id_ff[hit_ff];
                  rsp_ff.code_out     <= n_exit;
                  rsp_ff.parent_out   <= r_par;
                  rsp_ff.user_out     <= r_usr;
                  rsp_ff.group_out    <= r_grp;
                  rsp_ff.thread_count <= 16'(n_thr);
               end
               st_ff[hit_ff] <= n_st;
            end
            pst_pkg::S_DONE: begin
               if (found_ff) begin
                  rsp_ff.live_count <= 6'(live_ff);
               end else begin
                  rsp_ff <= pst_pkg::rsp_type'({{(RSPW - 6){1'b0}}, 6'(live_ff)});
               end
               rsp_valid_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

endmodule
